>>> hw/rtl/shct_pkg.sv
// ----------------------------------------------------------------------------
// shct_pkg
// Command and status codes shared by the chunk table and its channel
// interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package shct_pkg;

  // Command word codes
  localparam int unsigned CMD_W = 2;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  // Result status codes
  localparam int unsigned STATUS_W = 2;
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

endpackage

`default_nettype wire

>>> hw/rtl/shct_cmd_if.sv
// ----------------------------------------------------------------------------
// shct_cmd_if
// Command channel: valid/ready handshake with command, key and handle.
// ----------------------------------------------------------------------------
`default_nettype none

interface shct_cmd_if #(
  parameter int unsigned COORD_BITS  = 24,
  parameter int unsigned HANDLE_BITS = 16
) ();

  logic                           valid;
  logic                           ready;
  logic [shct_pkg::CMD_W-1:0]     command;
  logic signed [COORD_BITS-1:0]   coord_x;
  logic signed [COORD_BITS-1:0]   coord_y;
  logic signed [COORD_BITS-1:0]   coord_z;
  logic [HANDLE_BITS-1:0]         handle_in;

  modport source (
    output valid, command, coord_x, coord_y, coord_z, handle_in,
    input  ready
  );

  modport sink (
    input  valid, command, coord_x, coord_y, coord_z, handle_in,
    output ready
  );

endinterface

`default_nettype wire

>>> hw/rtl/shct_rsp_if.sv
// ----------------------------------------------------------------------------
// shct_rsp_if
// Result channel: valid/ready handshake with found flag, handle and status.
// ----------------------------------------------------------------------------
`default_nettype none

interface shct_rsp_if #(
  parameter int unsigned HANDLE_BITS = 16
) ();

  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [HANDLE_BITS-1:0]        handle_out;
  logic [shct_pkg::STATUS_W-1:0] status;

  modport source (
    output valid, found, handle_out, status,
    input  ready
  );

  modport sink (
    input  valid, found, handle_out, status,
    output ready
  );

endinterface

`default_nettype wire

>>> hw/rtl/spatial_hash_chunk_table.sv
// ----------------------------------------------------------------------------
// spatial_hash_chunk_table
// Map from signed 3D coordinates to a handle, one bucket row of WAYS slots
// per bucket, held in a single synchronous row memory.
// ----------------------------------------------------------------------------
//
//  Port    Dir   Modport  Word
//  ------  ----  -------  -----------------------------------------------
//  cmd_i   in    sink     command, coord_x, coord_y, coord_z, handle_in
//  rsp_o   out   source   found, handle_out, status
//
//  Steps per word: the accept edge registers key magnitudes, QUO runs the
//  per-axis reciprocal multiply, REM forms the remainders and the row
//  address and issues the memory read, RMW modifies the row and writes it
//  back through the single write port. No new word is taken until then.
//  Reset: a clearing pass writes every row empty, all BUCKETS_PER_AXIS**3
//  rows (4096 at the defaults); no command word is taken during it.
//  Stalls: a finished result waits in the output register while the next
//  command is taken; the write-back cycle holds until that register frees.
//
`default_nettype none

module spatial_hash_chunk_table #(
  parameter int unsigned BUCKETS_PER_AXIS = 16,
  parameter int unsigned WAYS             = 4,
  parameter int unsigned COORD_BITS       = 24,
  parameter int unsigned HANDLE_BITS      = 16
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  shct_cmd_if.sink     cmd_i,
  shct_rsp_if.source   rsp_o
);

  // --------------------------------------------------------------------------
  // Derived sizes
  // --------------------------------------------------------------------------
  localparam int unsigned C        = COORD_BITS;
  localparam int unsigned H        = HANDLE_BITS;
  localparam int unsigned B        = BUCKETS_PER_AXIS;
  localparam int unsigned BIW      = $clog2(B);
  localparam int unsigned RW       = $clog2(2 * B);
  localparam int unsigned NUM_ROWS = B * B * B;
  localparam int unsigned AW       = $clog2(NUM_ROWS);
  localparam int unsigned SLOT_W   = 1 + 3 * C + H;
  localparam int unsigned ROW_W    = WAYS * SLOT_W;
  localparam int unsigned VLD_BIT  = SLOT_W - 1;

  // floor(2^C / B): the quotient estimate is the true one or one short
  localparam logic [C-1:0] RECIP = C'((64'd1 << C) / B);

  // Sequencer states
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_QUO   = 3'd2;
  localparam logic [2:0] ST_REM   = 3'd3;
  localparam logic [2:0] ST_RMW   = 3'd4;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic [2:0]                    state_q, state_d;
  logic [AW-1:0]                 clr_cnt_q, clr_cnt_d;
  logic                          rsp_valid_q, rsp_valid_d;

  logic [shct_pkg::CMD_W-1:0]    cmd_q;
  logic [C-1:0]                  key_q  [3];
  logic [C-1:0]                  mag_q  [3];
  logic [C-1:0]                  quo_q  [3];
  logic [H-1:0]                  handle_q;
  logic [AW-1:0]                 addr_q;
  logic                          found_q;
  logic [H-1:0]                  hout_q;
  logic [shct_pkg::STATUS_W-1:0] status_q;

  logic [ROW_W-1:0]              row_mem_q [NUM_ROWS];
  logic [ROW_W-1:0]              rd_row_q;

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  logic cmd_take;
  logic out_free;
  logic rmw_go;
  logic clr_last;

  assign cmd_take = cmd_i.valid && cmd_i.ready;
  assign out_free = !rsp_valid_q || rsp_o.ready;
  assign rmw_go   = (state_q == ST_RMW) && out_free;
  assign clr_last = (clr_cnt_q == AW'(NUM_ROWS - 1));

  assign cmd_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    rsp_valid_d = rsp_valid_q;
    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
    case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_take) begin
          state_d = ST_QUO;
        end
      end
      ST_QUO: begin
        state_d = ST_REM;
      end
      ST_REM: begin
        state_d = ST_RMW;
      end
      ST_RMW: begin
        // hold until the output register can take the result
        if (rmw_go) begin
          state_d     = ST_IDLE;
          rsp_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // --------------------------------------------------------------------------
  // Bucket index: |v| mod B by reciprocal multiply and one correction
  // --------------------------------------------------------------------------
  logic [C-1:0] coord_in [3];
  logic [C-1:0] mag_in   [3];
  logic [C-1:0] rem_full [3];
  logic [RW-1:0] rem_small [3];
  logic [BIW-1:0] bucket [3];
  logic [AW-1:0] addr_d;

  assign coord_in[0] = cmd_i.coord_x;
  assign coord_in[1] = cmd_i.coord_y;
  assign coord_in[2] = cmd_i.coord_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // two's complement negate; the most negative value maps to 2^(C-1)
      mag_in[i]    = coord_in[i][C-1] ? (~coord_in[i] + 1'b1) : coord_in[i];
      rem_full[i]  = mag_q[i] - C'(quo_q[i] * B);
      rem_small[i] = rem_full[i][RW-1:0];
      if (rem_small[i] >= RW'(B)) begin
        rem_small[i] = rem_small[i] - RW'(B);
      end
      bucket[i] = rem_small[i][BIW-1:0];
    end
    addr_d = AW'((AW'(bucket[0]) * AW'(B) + AW'(bucket[1])) * AW'(B) + AW'(bucket[2]));
  end

  logic [2*C-1:0] prod [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i] = {{C{1'b0}}, mag_q[i]} * {{C{1'b0}}, RECIP};
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_take) begin
      cmd_q    <= cmd_i.command;
      handle_q <= cmd_i.handle_in;
      for (int i = 0; i < 3; i++) begin
        key_q[i] <= coord_in[i];
        mag_q[i] <= mag_in[i];
      end
    end
    if (state_q == ST_QUO) begin
      for (int i = 0; i < 3; i++) begin
        quo_q[i] <= prod[i][2*C-1:C];
      end
    end
    if (state_q == ST_REM) begin
      addr_q <= addr_d;
    end
  end

  // --------------------------------------------------------------------------
  // Row read-modify-write
  // --------------------------------------------------------------------------
  logic [WAYS-1:0]               hit_oh;
  logic [WAYS-1:0]               free_oh;
  logic                          any_hit;
  logic                          any_free;
  logic [H-1:0]                  hit_handle;
  logic [ROW_W-1:0]              new_row;
  logic                          res_found;
  logic [H-1:0]                  res_hout;
  logic [shct_pkg::STATUS_W-1:0] res_status;

  always_comb begin
    logic [SLOT_W-1:0] s;
    logic              vld;
    logic              match;
    any_hit    = 1'b0;
    any_free   = 1'b0;
    hit_oh     = '0;
    free_oh    = '0;
    hit_handle = '0;
    for (int w = 0; w < WAYS; w++) begin
      s     = rd_row_q[w*SLOT_W +: SLOT_W];
      vld   = s[VLD_BIT];
      match = vld && (s[H+2*C +: C] == key_q[0]) && (s[H+C +: C] == key_q[1]) &&
              (s[H +: C] == key_q[2]);
      if (match && !any_hit) begin
        hit_oh[w]  = 1'b1;
        any_hit    = 1'b1;
        hit_handle = s[H-1:0];
      end
      if (!vld && !any_free) begin
        free_oh[w] = 1'b1;
        any_free   = 1'b1;
      end
    end
  end

  always_comb begin
    new_row    = rd_row_q;
    res_found  = 1'b0;
    res_hout   = '0;
    res_status = shct_pkg::STATUS_OK;
    case (cmd_q)
      shct_pkg::CMD_INSERT: begin
        if (any_hit) begin
          // replace the handle in place
          res_found = 1'b1;
          for (int w = 0; w < WAYS; w++) begin
            if (hit_oh[w]) begin
              new_row[w*SLOT_W +: H] = handle_q;
            end
          end
        end else if (any_free) begin
          for (int w = 0; w < WAYS; w++) begin
            if (free_oh[w]) begin
              new_row[w*SLOT_W +: SLOT_W] = {1'b1, key_q[0], key_q[1], key_q[2], handle_q};
            end
          end
        end else begin
          res_status = shct_pkg::STATUS_FULL;
        end
      end
      shct_pkg::CMD_REMOVE: begin
        if (any_hit) begin
          res_found = 1'b1;
          for (int w = 0; w < WAYS; w++) begin
            if (hit_oh[w]) begin
              new_row[w*SLOT_W + VLD_BIT] = 1'b0;
            end
          end
        end else begin
          res_status = shct_pkg::STATUS_NOT_FOUND;
        end
      end
      default: begin
        // lookup, and the unused code three
        if (any_hit) begin
          res_found = 1'b1;
          res_hout  = hit_handle;
        end else begin
          res_status = shct_pkg::STATUS_NOT_FOUND;
        end
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Row memory: one write port, one registered read port
  // --------------------------------------------------------------------------
  logic             clearing;
  logic             mem_we;
  logic [AW-1:0]    wr_addr;
  logic [ROW_W-1:0] wr_row;
  logic [AW-1:0]    rd_addr;

  assign clearing = (state_q == ST_CLEAR);
  assign mem_we   = clearing || rmw_go;
  assign wr_addr  = clearing ? clr_cnt_q : addr_q;
  assign wr_row   = clearing ? '0 : new_row;
  // read the new row straight from the address logic, then hold it in RMW
  assign rd_addr  = (state_q == ST_REM) ? addr_d : addr_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      row_mem_q[wr_addr] <= wr_row;
    end
    rd_row_q <= row_mem_q[rd_addr];
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (rmw_go) begin
      found_q  <= res_found;
      hout_q   <= res_hout;
      status_q <= res_status;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.found      = found_q;
  assign rsp_o.handle_out = hout_q;
  assign rsp_o.status     = status_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_rsp_after_rmw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rmw_go |=> rsp_valid_q)
    else $error("result not presented after write-back");

  a_rmw_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RMW) && !rmw_go |=> (state_q == ST_RMW) && $stable(addr_q))
    else $error("stalled write-back lost its row");

  a_clear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing && clr_last |=> (state_q == ST_IDLE))
    else $error("clearing pass did not end after the last row");

  a_full_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && (status_q == shct_pkg::STATUS_FULL) |-> !found_q)
    else $error("refused insert reports a present key");

  a_handle_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && (hout_q != '0) |-> found_q && (status_q == shct_pkg::STATUS_OK))
    else $error("handle returned without a hit");

endmodule

`default_nettype wire

>>> test/tb_spatial_hash_chunk_table.sv
// ----------------------------------------------------------------------------
// tb_spatial_hash_chunk_table
// Self-checking bench for the chunk table. A short list of hand-written
// command words covers empty-table misses, insert, replace, remove, a full
// bucket and the spare command code. A long random run follows. Its keys
// crowd a few buckets and are reused often, so that hits, replaces and full
// buckets come up all the time. Each accepted word is run through a local
// copy of the table, and every reply is compared field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_spatial_hash_chunk_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BUCKETS     = 16;
  localparam int unsigned WAYS        = 4;
  localparam int unsigned COORD_BITS  = 24;
  localparam int unsigned HANDLE_BITS = 16;
  localparam int unsigned SLOTS       = BUCKETS * BUCKETS * BUCKETS * WAYS;

  localparam int CMAX = 8388607;
  localparam int CMIN = -8388608;

  // Spare command code; the block treats it as a lookup.
  localparam logic [shct_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;

  localparam int unsigned RESET_CYCLES = 3;
  localparam int unsigned RANDOM_WORDS = 1325;
  localparam int unsigned KEY_POOL     = 40;
  localparam int unsigned DRAIN_CYCLES = 16;
  // Watchdog bound: the clearing pass plus all directed and random words at worst.
  localparam int unsigned LIMIT_CYCLES = 400000;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic [shct_pkg::CMD_W-1:0] op;
    coord_t                     x;
    coord_t                     y;
    coord_t                     z;
    logic [HANDLE_BITS-1:0]     handle;
  } cmd_word_t;

  typedef struct packed {
    logic                          found;
    logic [HANDLE_BITS-1:0]        handle;
    logic [shct_pkg::STATUS_W-1:0] status;
  } reply_t;

  typedef struct {
    cmd_word_t word;
    bit        typed;   // reply below is checked as written
    reply_t    reply;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  shct_cmd_if #(.COORD_BITS(COORD_BITS), .HANDLE_BITS(HANDLE_BITS)) cmd_ch ();
  shct_rsp_if #(.HANDLE_BITS(HANDLE_BITS)) rsp_ch ();

  spatial_hash_chunk_table #(
    .BUCKETS_PER_AXIS(BUCKETS),
    .WAYS            (WAYS),
    .COORD_BITS      (COORD_BITS),
    .HANDLE_BITS     (HANDLE_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_ch),
    .rsp_o (rsp_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Local copy of the slot store; only valid slots are ever compared.
  bit                     slot_busy  [SLOTS];
  coord_t                 slot_x     [SLOTS];
  coord_t                 slot_y     [SLOTS];
  coord_t                 slot_z     [SLOTS];
  logic [HANDLE_BITS-1:0] slot_handle[SLOTS];

  reply_t      awaited_replies[$];
  dir_row_t    directed_rows[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;

  coord_t pool_x[KEY_POOL];
  coord_t pool_y[KEY_POOL];
  coord_t pool_z[KEY_POOL];

  // Axis bucket: magnitude of the signed coordinate, modulo the bucket count.
  // Widen first so the most negative value keeps its full magnitude.
  function automatic int unsigned axis_bucket(coord_t v);
    longint mag;
    mag = (v < 0) ? -longint'(v) : longint'(v);
    return int'(mag % BUCKETS);
  endfunction

  // Apply one command word to the local table and return the reply it earns.
  function automatic reply_t resolve_command(cmd_word_t w);
    int unsigned base;
    int          hit;
    int          free_way;
    reply_t      r;
    base = ((axis_bucket(w.x) * BUCKETS + axis_bucket(w.y)) * BUCKETS
            + axis_bucket(w.z)) * WAYS;
    hit = -1;
    free_way = -1;
    for (int k = 0; k < WAYS; k++) begin
      if (slot_busy[base + k]) begin
        if (hit < 0 && slot_x[base + k] == w.x && slot_y[base + k] == w.y &&
            slot_z[base + k] == w.z)
          hit = k;
      end else if (free_way < 0) begin
        free_way = k;
      end
    end
    r.found  = 1'b0;
    r.handle = '0;
    r.status = shct_pkg::STATUS_OK;
    case (w.op)
      shct_pkg::CMD_INSERT: begin
        if (hit >= 0) begin
          slot_handle[base + hit] = w.handle;
          r.found = 1'b1;
        end else if (free_way >= 0) begin
          slot_busy[base + free_way]   = 1'b1;
          slot_x[base + free_way]      = w.x;
          slot_y[base + free_way]      = w.y;
          slot_z[base + free_way]      = w.z;
          slot_handle[base + free_way] = w.handle;
        end else begin
          r.status = shct_pkg::STATUS_FULL;
        end
      end
      shct_pkg::CMD_REMOVE: begin
        if (hit >= 0) begin
          slot_busy[base + hit] = 1'b0;
          r.found = 1'b1;
        end else begin
          r.status = shct_pkg::STATUS_NOT_FOUND;
        end
      end
      default: begin
        // lookup, and the spare code behaves the same
        if (hit >= 0) begin
          r.found  = 1'b1;
          r.handle = slot_handle[base + hit];
        end else begin
          r.status = shct_pkg::STATUS_NOT_FOUND;
        end
      end
    endcase
    return r;
  endfunction

  // Build one directed row and append it to the stimulus list.
  function automatic void add_row(logic [shct_pkg::CMD_W-1:0] op, int x, int y, int z,
                                  int h, bit typed, bit f, int ho,
                                  logic [shct_pkg::STATUS_W-1:0] st);
    dir_row_t d;
    d.word.op     = op;
    d.word.x      = coord_t'(x);
    d.word.y      = coord_t'(y);
    d.word.z      = coord_t'(z);
    d.word.handle = HANDLE_BITS'(h);
    d.typed        = typed;
    d.reply.found  = f;
    d.reply.handle = HANDLE_BITS'(ho);
    d.reply.status = st;
    directed_rows.insert(directed_rows.size(), d);
  endfunction

  // Coordinate whose axis bucket is 0 or 1, so random keys pile up in a few
  // buckets and fill them.
  function automatic coord_t crowded_coord();
    int mag;
    mag = int'($urandom_range(0, 524287)) * BUCKETS + int'($urandom_range(0, 1));
    return coord_t'($urandom_range(0, 1) ? -mag : mag);
  endfunction

  // Draw a key: half the time from the recent pool, else a fresh crowded or raw key.
  function automatic void pick_key(output coord_t x, output coord_t y,
                                   output coord_t z);
    int unsigned r;
    int unsigned slot;
    r = $urandom_range(0, 99);
    slot = $urandom_range(0, KEY_POOL - 1);
    if (r < 50) begin
      x = pool_x[slot];
      y = pool_y[slot];
      z = pool_z[slot];
    end else begin
      if (r < 85) begin
        x = crowded_coord();
        y = crowded_coord();
        z = crowded_coord();
      end else begin
        x = coord_t'($urandom);
        y = coord_t'($urandom);
        z = coord_t'($urandom);
      end
      pool_x[slot] = x;
      pool_y[slot] = y;
      pool_z[slot] = z;
    end
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Present one word, hold it until taken, then book the reply it earns.
  task automatic issue_word(cmd_word_t w, bit typed, reply_t typed_reply);
    reply_t predicted;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.command   <= w.op;
    cmd_ch.coord_x   <= w.x;
    cmd_ch.coord_y   <= w.y;
    cmd_ch.coord_z   <= w.z;
    cmd_ch.handle_in <= w.handle;
    do
      @(posedge clk_i);
    while (cmd_ch.ready !== 1'b1);
    // Step the local table on every word, typed or not, to keep it in sync.
    predicted = resolve_command(w);
    awaited_replies.insert(awaited_replies.size(), typed ? typed_reply : predicted);
  endtask

  // Reply checker and receiver stall; sample the pre-edge values.
  always @(posedge clk_i) begin
    reply_t head;
    if (rst_ni && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (awaited_replies.size() == 0) begin
        report_mismatch("reply with no command outstanding");
      end else begin
        head = awaited_replies.pop_front();
        if (rsp_ch.found !== head.found)
          report_mismatch($sformatf("found %b, want %b", rsp_ch.found, head.found));
        if (rsp_ch.handle_out !== head.handle)
          report_mismatch($sformatf("handle_out %h, want %h",
                                    rsp_ch.handle_out, head.handle));
        if (rsp_ch.status !== head.status)
          report_mismatch($sformatf("status %0d, want %0d",
                                    rsp_ch.status, head.status));
      end
    end
    rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    cmd_word_t w;
    reply_t    no_reply;
    int unsigned r;

    cmd_ch.valid     <= 1'b0;
    cmd_ch.command   <= shct_pkg::CMD_LOOKUP;
    cmd_ch.coord_x   <= '0;
    cmd_ch.coord_y   <= '0;
    cmd_ch.coord_z   <= '0;
    cmd_ch.handle_in <= '0;
    no_reply = '0;

    // Directed words. Origin, the most negative corner and (16,-16,32),
    // (-32,48,-8388592) all land in bucket (0,0,0); with four ways the fifth
    // key is refused. The most positive corner lands in bucket (15,15,15).
    add_row(shct_pkg::CMD_LOOKUP, 0, 0, 0, 'hFFFF, 1, 0, 0, shct_pkg::STATUS_NOT_FOUND);
    add_row(shct_pkg::CMD_REMOVE, 0, 0, 0, 0, 1, 0, 0, shct_pkg::STATUS_NOT_FOUND);
    add_row(shct_pkg::CMD_INSERT, 0, 0, 0, 'hFFFF, 1, 0, 0, shct_pkg::STATUS_OK);
    add_row(shct_pkg::CMD_LOOKUP, 0, 0, 0, 0, 1, 1, 'hFFFF, shct_pkg::STATUS_OK);
    add_row(shct_pkg::CMD_INSERT, 0, 0, 0, 0, 0, 0, 0, shct_pkg::STATUS_OK);
    add_row(CMD_SPARE, 0, 0, 0, 'h1234, 0, 0, 0, shct_pkg::STATUS_OK);
    add_row(shct_pkg::CMD_INSERT, CMAX, CMAX, CMAX, 'h1234, 1, 0, 0, shct_pkg::STATUS_OK);
    add_row(shct_pkg::CMD_INSERT, CMIN, CMIN, CMIN, 'hA5A5, 1, 0, 0, shct_pkg::STATUS_OK);
    add_row(shct_pkg::CMD_INSERT, 16, -16, 32, 'h0001, 0, 0, 0, shct_pkg::STATUS_OK);
    add_row(shct_pkg::CMD_INSERT, -32, 48, -8388592, 'h8000, 0, 0, 0, shct_pkg::STATUS_OK);
    add_row(shct_pkg::CMD_INSERT, 64, 0, 0, 'h7FFF, 1, 0, 0, shct_pkg::STATUS_FULL);
    add_row(shct_pkg::CMD_LOOKUP, CMIN, CMIN, CMIN, 0, 1, 1, 'hA5A5, shct_pkg::STATUS_OK);
    add_row(shct_pkg::CMD_REMOVE, 16, -16, 32, 'hFFFF, 1, 1, 0, shct_pkg::STATUS_OK);
    add_row(shct_pkg::CMD_INSERT, 64, 0, 0, 'h5A5A, 0, 0, 0, shct_pkg::STATUS_OK);
    add_row(shct_pkg::CMD_LOOKUP, 64, 0, 0, 0, 0, 0, 0, shct_pkg::STATUS_OK);
    add_row(shct_pkg::CMD_REMOVE, CMIN, CMIN, CMIN, 0, 1, 1, 0, shct_pkg::STATUS_OK);
    add_row(shct_pkg::CMD_LOOKUP, CMIN, CMIN, CMIN, 0, 1, 0, 0, shct_pkg::STATUS_NOT_FOUND);
    add_row(shct_pkg::CMD_LOOKUP, CMAX, CMAX, CMAX, 0, 1, 1, 'h1234, shct_pkg::STATUS_OK);
    // same bucket, different signs: keys must not alias
    add_row(shct_pkg::CMD_INSERT, -1, 1, -15, 'h8001, 0, 0, 0, shct_pkg::STATUS_OK);
    add_row(shct_pkg::CMD_LOOKUP, 1, -1, 15, 'hFFFF, 1, 0, 0, shct_pkg::STATUS_NOT_FOUND);
    add_row(shct_pkg::CMD_LOOKUP, -1, 1, -15, 0, 0, 0, 0, shct_pkg::STATUS_OK);
    add_row(CMD_SPARE, 5, 5, 5, 0, 1, 0, 0, shct_pkg::STATUS_NOT_FOUND);
    add_row(shct_pkg::CMD_REMOVE, -1, 1, -15, 0, 0, 0, 0, shct_pkg::STATUS_OK);
    add_row(shct_pkg::CMD_REMOVE, -1, 1, -15, 0, 1, 0, 0, shct_pkg::STATUS_NOT_FOUND);
    add_row(shct_pkg::CMD_INSERT, 0, 0, 0, 'hABCD, 1, 1, 0, shct_pkg::STATUS_OK);

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The clearing pass after reset shows up as ready held low; just wait.
    foreach (directed_rows[i])
      issue_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].reply);

    for (int i = 0; i < KEY_POOL; i++) begin
      pool_x[i] = crowded_coord();
      pool_y[i] = crowded_coord();
      pool_z[i] = crowded_coord();
    end

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      // Four stretches: free flow, sender gaps, receiver stalls, both.
      case (i * 4 / RANDOM_WORDS)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 68; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 68; end
        default: begin send_gap_pct = 18; recv_stall_pct = 18; end
      endcase
      r = $urandom_range(0, 99);
      if (r < 45)      w.op = shct_pkg::CMD_INSERT;
      else if (r < 75) w.op = shct_pkg::CMD_LOOKUP;
      else if (r < 95) w.op = shct_pkg::CMD_REMOVE;
      else             w.op = CMD_SPARE;
      pick_key(w.x, w.y, w.z);
      w.handle = HANDLE_BITS'($urandom);
      issue_word(w, 1'b0, no_reply);
    end
    cmd_ch.valid <= 1'b0;

    // Drain outstanding replies, then watch a few more cycles for strays.
    while (awaited_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
hw/rtl/shct_pkg.sv
hw/rtl/shct_cmd_if.sv
hw/rtl/shct_rsp_if.sv
hw/rtl/spatial_hash_chunk_table.sv
test/tb_spatial_hash_chunk_table.sv
